// ===== rtl/tbgd_pkg.sv =====
`timescale 1ns / 1ps
package tbgd_pkg;

   // register indexes on the csr channel
   localparam logic [1:0] REG_LONG_PRESS     = 2'd0;
   localparam logic [1:0] REG_CHORD_SHUTDOWN = 2'd1;
   localparam logic [1:0] REG_CHORD_PROMPT   = 2'd2;
   localparam logic [1:0] REG_ACTION_GAP     = 2'd3;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CFG_WIDTH       = 16;
   localparam int NOW_WIDTH       = 32;

   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET     = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] CHORD_SHUTDOWN_RESET = 16'd3000;
   localparam logic [CFG_WIDTH-1:0] CHORD_PROMPT_RESET   = 16'd1500;
   localparam logic [CFG_WIDTH-1:0] ACTION_GAP_RESET     = 16'd50;

   // request word: up_level, down_level, now_time, padded to bytes
   localparam int REQ_DATA_WIDTH = 40;
   localparam int REQ_UP_BIT     = 0;
   localparam int REQ_DOWN_BIT   = 1;
   localparam int REQ_NOW_LSB    = 2;

   // response word: six event flags, padded to a byte
   localparam int RSP_DATA_WIDTH = 8;
   localparam int RSP_EVENTS     = 6;
   localparam int RSP_PROMPT     = 0;
   localparam int RSP_SHUTDOWN   = 1;
   localparam int RSP_LONG_UP    = 2;
   localparam int RSP_LONG_DOWN  = 3;
   localparam int RSP_SHORT_UP   = 4;
   localparam int RSP_SHORT_DOWN = 5;

endpackage

// ===== rtl/two_button_gesture_detector.sv =====
`timescale 1ns / 1ps
// A word accepted on req passes through the input register and the result register before it appears on rsp.
// Throughput: one snapshot per cycle while rsp is not stalled; an input register and a result register hold
// the two stages, and all state updates in the single compute stage between them.
// Reset is synchronous and active high: it clears the gesture state, the stage valid
// flags and returns the four timing registers to their default values.
module two_button_gesture_detector
   import tbgd_pkg::*;
#(
   parameter int TIME_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [0] up_level, [1] down_level, [33:2] now_time, [39:34] zero
   input  logic [REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [0] prompt_event, [1] shutdown_event, [2] long_up_event, [3] long_down_event,
   // [4] short_up_event, [5] short_down_event, [7:6] zero
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_data
);

   localparam int TW = TIME_WIDTH;

   typedef logic [TW-1:0] time_type;

   // configuration
   logic [CFG_WIDTH-1:0] long_press_ff, chord_shutdown_ff, chord_prompt_ff, action_gap_ff;

   // input stage
   logic                 in_valid_ff;
   logic                 in_up_ff, in_down_ff;
   logic [NOW_WIDTH-1:0] in_now_ff;

   // result stage
   logic                   rsp_valid_ff;
   logic [RSP_EVENTS-1:0]  rsp_events_ff, rsp_events_in;

   // gesture state
   logic     prev_up_ff, prev_down_ff;
   time_type up_start_ff, down_start_ff, chord_start_ff, last_action_ff;
   logic     up_long_done_ff, down_long_done_ff;
   logic     chord_active_ff, chord_long_done_ff, prompt_done_ff;

   time_type up_start_in, down_start_in, chord_start_in, last_action_in;
   logic     up_long_done_in, down_long_done_in;
   logic     chord_active_in, chord_long_done_in, prompt_done_in;

   logic advance;
   logic [TW+NOW_WIDTH-1:0] now_ext;
   time_type now, held, up_held, down_held, gap_held;
   time_type long_press_t, chord_shutdown_t, chord_prompt_t, action_gap_t;
   logic up_rise, down_rise, up_rel, down_rel;
   logic up_ld0, down_ld0;
   logic ev_prompt, ev_shut, ev_lup, ev_ldown, ev_sup, ev_sdown;
   logic gap_ok_up, gap_ok_down;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-RSP_EVENTS){1'b0}}, rsp_events_ff};

   // time taken modulo 2^TIME_WIDTH
   assign now_ext = {{TW{1'b0}}, in_now_ff};
   assign now     = now_ext[TW-1:0];

   assign long_press_t     = time_type'({{TW{1'b0}}, long_press_ff});
   assign chord_shutdown_t = time_type'({{TW{1'b0}}, chord_shutdown_ff});
   assign chord_prompt_t   = time_type'({{TW{1'b0}}, chord_prompt_ff});
   assign action_gap_t     = time_type'({{TW{1'b0}}, action_gap_ff});

   always_comb begin
      up_rise  = in_up_ff && !prev_up_ff;
      down_rise = in_down_ff && !prev_down_ff;
      up_rel   = prev_up_ff && !in_up_ff;
      down_rel = prev_down_ff && !in_down_ff;

      up_ld0   = up_rise ? 1'b0 : up_long_done_ff;
      down_ld0 = down_rise ? 1'b0 : down_long_done_ff;

      // press start reads as zero while released
      up_start_in   = !in_up_ff ? '0 : (up_rise ? now : up_start_ff);
      down_start_in = !in_down_ff ? '0 : (down_rise ? now : down_start_ff);

      up_held   = now - up_start_in;
      down_held = now - down_start_in;
      held      = chord_active_ff ? (now - chord_start_ff) : '0;
      gap_held  = now - last_action_ff;

      up_long_done_in    = up_ld0;
      down_long_done_in  = down_ld0;
      chord_active_in    = chord_active_ff;
      chord_start_in     = chord_start_ff;
      chord_long_done_in = chord_long_done_ff;
      prompt_done_in     = prompt_done_ff;
      last_action_in     = last_action_ff;

      ev_prompt   = 1'b0;
      ev_shut     = 1'b0;
      ev_lup      = 1'b0;
      ev_ldown    = 1'b0;
      ev_sup      = 1'b0;
      ev_sdown    = 1'b0;
      gap_ok_up   = 1'b0;
      gap_ok_down = 1'b0;

      if (in_up_ff && in_down_ff) begin
         chord_active_in = 1'b1;
         if (!chord_active_ff) begin
            chord_start_in     = now;
            chord_long_done_in = 1'b0;
            prompt_done_in     = 1'b0;
         end
         ev_prompt = (held >= chord_prompt_t) && !prompt_done_in;
         ev_shut   = (held >= chord_shutdown_t) && !chord_long_done_in;
         if (ev_prompt) prompt_done_in = 1'b1;
         if (ev_shut) begin
            chord_long_done_in = 1'b1;
            last_action_in     = now;
         end
      end else if (chord_active_ff) begin
         if (!in_up_ff && !in_down_ff) begin
            chord_active_in    = 1'b0;
            chord_start_in     = '0;
            chord_long_done_in = 1'b0;
            prompt_done_in     = 1'b0;
         end
      end else begin
         ev_lup   = in_up_ff && !up_ld0 && (up_start_in != '0) && (up_held >= long_press_t);
         ev_ldown = in_down_ff && !down_ld0 && (down_start_in != '0)
                    && (down_held >= long_press_t);
         // an action earlier in this snapshot leaves zero elapsed time
         gap_ok_up   = (ev_lup || ev_ldown) ? (action_gap_t == '0) : (gap_held >= action_gap_t);
         ev_sup      = up_rel && !up_ld0 && gap_ok_up;
         gap_ok_down = (ev_lup || ev_ldown || ev_sup) ? (action_gap_t == '0)
                       : (gap_held >= action_gap_t);
         ev_sdown    = down_rel && !down_ld0 && gap_ok_down;
         if (ev_lup || ev_ldown || ev_sup || ev_sdown) last_action_in = now;
         if (ev_lup) up_long_done_in = 1'b1;
         if (ev_ldown) down_long_done_in = 1'b1;
         if (up_rel) up_long_done_in = 1'b0;
         if (down_rel) down_long_done_in = 1'b0;
      end

      rsp_events_in = '0;
      rsp_events_in[RSP_PROMPT]     = ev_prompt;
      rsp_events_in[RSP_SHUTDOWN]   = ev_shut;
      rsp_events_in[RSP_LONG_UP]    = ev_lup;
      rsp_events_in[RSP_LONG_DOWN]  = ev_ldown;
      rsp_events_in[RSP_SHORT_UP]   = ev_sup;
      rsp_events_in[RSP_SHORT_DOWN] = ev_sdown;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff     <= LONG_PRESS_RESET;
         chord_shutdown_ff <= CHORD_SHUTDOWN_RESET;
         chord_prompt_ff   <= CHORD_PROMPT_RESET;
         action_gap_ff     <= ACTION_GAP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_LONG_PRESS:     long_press_ff     <= csr_data;
            REG_CHORD_SHUTDOWN: chord_shutdown_ff <= csr_data;
            REG_CHORD_PROMPT:   chord_prompt_ff   <= csr_data;
            REG_ACTION_GAP:     action_gap_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_up_ff   <= req_tdata[REQ_UP_BIT];
         in_down_ff <= req_tdata[REQ_DOWN_BIT];
         in_now_ff  <= req_tdata[REQ_NOW_LSB +: NOW_WIDTH];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_events_ff <= rsp_events_in;
      end
   end

   // gesture state, updated once per snapshot
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_up_ff         <= 1'b0;
         prev_down_ff       <= 1'b0;
         up_start_ff        <= '0;
         down_start_ff      <= '0;
         chord_start_ff     <= '0;
         last_action_ff     <= '0;
         up_long_done_ff    <= 1'b0;
         down_long_done_ff  <= 1'b0;
         chord_active_ff    <= 1'b0;
         chord_long_done_ff <= 1'b0;
         prompt_done_ff     <= 1'b0;
      end else if (advance) begin
         prev_up_ff         <= in_up_ff;
         prev_down_ff       <= in_down_ff;
         up_start_ff        <= up_start_in;
         down_start_ff      <= down_start_in;
         chord_start_ff     <= chord_start_in;
         last_action_ff     <= last_action_in;
         up_long_done_ff    <= up_long_done_in;
         down_long_done_ff  <= down_long_done_in;
         chord_active_ff    <= chord_active_in;
         chord_long_done_ff <= chord_long_done_in;
         prompt_done_ff     <= prompt_done_in;
      end
   end

endmodule

// ===== rtl/tbgd_checker.sv =====
`timescale 1ns / 1ps
module tbgd_checker
   import tbgd_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0]  rsp_tdata
);

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response word changed");

   // drop every response after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // chord events and single-button events never share a word
   a_chord_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !((rsp_tdata[RSP_PROMPT] || rsp_tdata[RSP_SHUTDOWN]) &&
                       (rsp_tdata[RSP_LONG_UP] || rsp_tdata[RSP_LONG_DOWN] ||
                        rsp_tdata[RSP_SHORT_UP] || rsp_tdata[RSP_SHORT_DOWN])))
      else $error("chord and single-button events together");

   // a button cannot be both held long and released in one snapshot
   a_long_short: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[RSP_LONG_UP] && rsp_tdata[RSP_SHORT_UP]) &&
                     !(rsp_tdata[RSP_LONG_DOWN] && rsp_tdata[RSP_SHORT_DOWN]))
      else $error("long and short press of one button together");

endmodule

bind two_button_gesture_detector tbgd_checker u_tbgd_checker (.*);
